[design/serial_image_loader_assert.svh]
// assertion macros for the serial image loader
// no dependencies; included by serial_image_loader to check its own logic
`ifndef SERIAL_IMAGE_LOADER_ASSERT_SVH
`define SERIAL_IMAGE_LOADER_ASSERT_SVH
`ifndef ASSERT_OFF
// invariant checked at every clock edge outside reset
`define SIL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sil assertion failed");
// implication checked at every clock edge outside reset
`define SIL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sil assertion failed");
`else
`define SIL_ASSERT(lbl, clk, rst, prop)
`define SIL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`endif
`endif

[design/sil_pkg.sv]
// shared types, reply codes and helpers for the serial image loader
// no dependencies
package sil_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [31:0] word_type;

   // protocol characters
   localparam byte_type CharLowerA = 8'h61;
   localparam byte_type CharUpperA = 8'h41;
   localparam byte_type CharE      = 8'h45;
   localparam byte_type CharC      = 8'h43;
   localparam byte_type CharNl     = 8'h0a;
   localparam byte_type CharLowerS = 8'h73;
   localparam byte_type CharR      = 8'h52;

   // result queue geometry
   localparam int QDepth = 4;
   localparam int QIdxW  = $clog2(QDepth);
   localparam int QCntW  = QIdxW + 1;

   typedef struct packed {
      logic     tx_valid;
      byte_type tx_byte;
      logic     wr_valid;
      word_type wr_addr;
      byte_type wr_data;
      logic     done_res;
      word_type jump_addr;
      logic     last;
   } res_type;

   // replace one byte lane of a little-endian word
   function automatic word_type put_byte(word_type word, logic [1:0] idx, byte_type b);
      word_type r;
      r = word;
      case (idx)
         2'd0:    r[7:0]   = b;
         2'd1:    r[15:8]  = b;
         2'd2:    r[23:16] = b;
         default: r[31:24] = b;
      endcase
      return r;
   endfunction

endpackage

[design/serial_image_loader.sv]
// serial boot loader handshake: byte in, replies / image writes / done out
// depends on sil_pkg and serial_image_loader_assert.svh
// results pass through the input register and then the result queue before they
//   reach rsp_; a queue without room for two holds the byte in the input register
// throughput: one byte per cycle while each byte yields at most one result and rsp_ready
//   stays high; a run of bytes with two results each is held back by the output
// a byte is processed when its input register is full and the queue has room for two
// reset: synchronous active high, returns to waiting for the start byte, queue empty
`include "serial_image_loader_assert.svh"
module serial_image_loader (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  sil_pkg::byte_type  req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_tx_valid,
   output sil_pkg::byte_type  rsp_tx_byte,
   output logic               rsp_wr_valid,
   output sil_pkg::word_type  rsp_wr_addr,
   output sil_pkg::byte_type  rsp_wr_data,
   output logic               rsp_done_res,
   output sil_pkg::word_type  rsp_jump_addr,
   output logic               rsp_last
);
   import sil_pkg::*;

   typedef enum logic [2:0] {
      PH_WAIT_A  = 3'd0,
      PH_ADDR    = 3'd1,
      PH_SKIP_NL = 3'd2,
      PH_WAIT_S  = 3'd3,
      PH_COUNT   = 3'd4,
      PH_DATA    = 3'd5,
      PH_DONE    = 3'd6
   } phase_type;

   // input register
   logic       in_vld_ff, in_vld_in;
   byte_type   in_byte_ff;

   // protocol state
   phase_type  phase_ff, phase_in;
   logic [1:0] idx_ff, idx_in;
   word_type   load_ff, load_in;
   word_type   remain_ff, remain_in;
   word_type   wptr_ff, wptr_in;

   // result queue
   res_type            q_ff [QDepth];
   logic [QIdxW-1:0]   head_ff, tail_ff;
   logic [QCntW-1:0]   count_ff;

   logic       go;
   logic       pop;
   logic [1:0] n_res;
   res_type    r0, r1;
   word_type   cnt_new;
   res_type    head;

   // process only when the queue can take the worst case of two results
   assign go        = in_vld_ff && (count_ff <= QCntW'(QDepth - 2));
   assign req_ready = !in_vld_ff || go;
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (go) begin
         in_vld_in = 1'b0;
      end
   end

   // one byte through the protocol: next state and up to two results
   always_comb begin
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      load_in   = load_ff;
      remain_in = remain_ff;
      wptr_in   = wptr_ff;
      r0        = '0;
      r1        = '0;
      n_res     = 2'd0;
      cnt_new   = put_byte(remain_ff, idx_ff, in_byte_ff);
      if (go) begin
         case (phase_ff)
            PH_WAIT_A: begin
               r0.tx_valid = 1'b1;
               n_res       = 2'd1;
               if (in_byte_ff == CharLowerA) begin
                  r0.tx_byte = CharUpperA;
                  phase_in   = PH_ADDR;
                  idx_in     = 2'd0;
               end else begin
                  r0.tx_byte = CharE;
               end
            end
            PH_ADDR: begin
               load_in = put_byte(load_ff, idx_ff, in_byte_ff);
               if (idx_ff == 2'd3) begin
                  r0.tx_valid = 1'b1;
                  r0.tx_byte  = CharC;
                  n_res       = 2'd1;
                  idx_in      = 2'd0;
                  phase_in    = PH_SKIP_NL;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
            PH_SKIP_NL, PH_WAIT_S: begin
               // newlines are dropped only before the first other byte
               if (!(phase_ff == PH_SKIP_NL && in_byte_ff == CharNl)) begin
                  r0.tx_valid = 1'b1;
                  if (in_byte_ff == CharLowerS) begin
                     r0.tx_byte = CharR;
                     n_res      = 2'd1;
                     idx_in     = 2'd0;
                     phase_in   = PH_COUNT;
                  end else begin
                     // error reply followed by the echo
                     r0.tx_byte  = CharE;
                     r1.tx_valid = 1'b1;
                     r1.tx_byte  = in_byte_ff;
                     n_res       = 2'd2;
                     phase_in    = PH_WAIT_S;
                  end
               end
            end
            PH_COUNT: begin
               remain_in = cnt_new;
               if (idx_ff == 2'd3) begin
                  r0.tx_valid = 1'b1;
                  r0.tx_byte  = CharC;
                  n_res       = 2'd1;
                  idx_in      = 2'd0;
                  wptr_in     = load_ff;
                  if (cnt_new == '0) begin
                     // empty image: done right behind the ack
                     r1.done_res  = 1'b1;
                     r1.jump_addr = load_ff;
                     n_res        = 2'd2;
                     phase_in     = PH_DONE;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
            PH_DATA: begin
               r0.wr_valid = 1'b1;
               r0.wr_addr  = wptr_ff;
               r0.wr_data  = in_byte_ff;
               n_res       = 2'd1;
               wptr_in     = wptr_ff + 32'd1;
               remain_in   = remain_ff - 32'd1;
               if (remain_ff == 32'd1) begin
                  r1.done_res  = 1'b1;
                  r1.jump_addr = load_ff;
                  n_res        = 2'd2;
                  phase_in     = PH_DONE;
               end
            end
            default: begin
               // finished, and the unused code: bytes are dropped
            end
         endcase
      end
      if (n_res == 2'd2) begin
         r1.last = 1'b1;
      end else if (n_res == 2'd1) begin
         r0.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         phase_ff  <= PH_WAIT_A;
         idx_ff    <= 2'd0;
         load_ff   <= '0;
         remain_ff <= '0;
         wptr_ff   <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         load_ff   <= load_in;
         remain_ff <= remain_in;
         wptr_ff   <= wptr_in;
         head_ff   <= head_ff + QIdxW'(pop);
         tail_ff   <= tail_ff + QIdxW'(n_res);
         count_ff  <= count_ff + QCntW'(n_res) - QCntW'(pop);
      end
   end

   // input payload and queue entries carry no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (n_res != 2'd0) begin
         q_ff[tail_ff] <= r0;
      end
      if (n_res == 2'd2) begin
         q_ff[tail_ff + QIdxW'(1)] <= r1;
      end
   end

   assign head          = q_ff[head_ff];
   assign rsp_valid     = (count_ff != '0);
   assign rsp_tx_valid  = head.tx_valid;
   assign rsp_tx_byte   = head.tx_byte;
   assign rsp_wr_valid  = head.wr_valid;
   assign rsp_wr_addr   = head.wr_addr;
   assign rsp_wr_data   = head.wr_data;
   assign rsp_done_res  = head.done_res;
   assign rsp_jump_addr = head.jump_addr;
   assign rsp_last      = head.last;

   // queue never overfills
   `SIL_ASSERT(a_q_bound, clock, reset, count_ff <= QCntW'(QDepth))
   // a push never lands on a queue without room for two
   `SIL_ASSERT_IMP(a_push_room, clock, reset, n_res != 2'd0, count_ff <= QCntW'(QDepth - 2))
   // a done result at the head means the protocol has finished
   `SIL_ASSERT_IMP(a_done_phase, clock, reset, rsp_valid && rsp_done_res, phase_ff == PH_DONE)
   // an image write never carries a reply byte
   `SIL_ASSERT_IMP(a_wr_no_tx, clock, reset, rsp_valid && rsp_wr_valid, !rsp_tx_valid)

endmodule

[bench/serial_image_loader_test.sv]
// self-checking testbench for serial_image_loader: directed handshake table, then random
// noise, count and image data, checked against typed table replies and a built-in loader predictor
// depends on sil_pkg and the serial_image_loader rtl
module serial_image_loader_test;
   timeunit 1ns;
   timeprecision 1ps;

   import sil_pkg::*;

   // watchdog, far above the slowest legal run of at most 1072 bytes
   localparam int CycleLimit = 200000;
   // drain time after the last expected result: covers the latency plus the queue depth
   localparam int DrainCycles = 12;
   localparam int ReportLimit = 10;
   // table rows with this reply count are left to the predictor
   localparam int Predicted = -1;

   // loader phases as the predictor tracks them
   typedef enum logic [2:0] {
      WaitStart, GetAddr, SkipNl, WaitS, GetCount, LoadData, Finished
   } load_phase_type;

   // one row of the directed table
   typedef struct {
      byte_type rx;
      int       n_typed;
      byte_type t0;
      byte_type t1;
   } row_type;

   logic     clock;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   byte_type req_rx_byte = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   logic     rsp_tx_valid;
   byte_type rsp_tx_byte;
   logic     rsp_wr_valid;
   word_type rsp_wr_addr;
   byte_type rsp_wr_data;
   logic     rsp_done_res;
   word_type rsp_jump_addr;
   logic     rsp_last;

   // predictor state
   load_phase_type ld_phase = WaitStart;
   logic [1:0]     ld_lane = '0;
   word_type       ld_addr = '0;
   word_type       ld_remaining = '0;
   word_type       ld_ptr = '0;

   res_type expected_results [$];
   row_type dir_rows [$];

   // idle percentages, stepped by the sender as the run goes on
   int send_idle = 15;
   int recv_idle = 56;

   int bytes_sent = 0;
   int results_checked = 0;
   int writes_seen = 0;
   int failures = 0;
   bit wrap_seen = 1'b0;
   bit done_seen = 1'b0;

   serial_image_loader dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_tx_valid  (rsp_tx_valid),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_wr_valid  (rsp_wr_valid),
      .rsp_wr_addr   (rsp_wr_addr),
      .rsp_wr_data   (rsp_wr_data),
      .rsp_done_res  (rsp_done_res),
      .rsp_jump_addr (rsp_jump_addr),
      .rsp_last      (rsp_last)
   );

   // 4 ns clock
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // a reply-only result carrying one transmit byte
   function automatic res_type reply(input byte_type c);
      res_type r;
      r = '0;
      r.tx_valid = 1'b1;
      r.tx_byte = c;
      return r;
   endfunction

   function automatic string describe(input res_type r);
      return $sformatf("tx %0b/%h wr %0b/%h/%h done %0b/%h last %0b", r.tx_valid, r.tx_byte,
         r.wr_valid, r.wr_addr, r.wr_data, r.done_res, r.jump_addr, r.last);
   endfunction

   function automatic bit fields_match(input res_type a, input res_type b);
      return a.tx_valid === b.tx_valid && a.tx_byte === b.tx_byte &&
         a.wr_valid === b.wr_valid && a.wr_addr === b.wr_addr &&
         a.wr_data === b.wr_data && a.done_res === b.done_res &&
         a.jump_addr === b.jump_addr && a.last === b.last;
   endfunction

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= ReportLimit)
         $display("mismatch: %s", msg);
   endtask

   // step the loader predictor by one received byte; queue its results when keep is set
   task automatic advance_loader(input byte_type b, input bit keep);
      res_type r [2];
      int n;
      n = 0;
      r[0] = '0;
      r[1] = '0;
      case (ld_phase)
         WaitStart: begin
            if (b == CharLowerA) begin
               r[n] = reply(CharUpperA);
               n++;
               ld_phase = GetAddr;
               ld_lane = '0;
            end else begin
               r[n] = reply(CharE);
               n++;
            end
         end
         GetAddr: begin
            ld_addr[ld_lane * 8 +: 8] = b;
            if (ld_lane == 2'd3) begin
               r[n] = reply(CharC);
               n++;
               ld_lane = '0;
               ld_phase = SkipNl;
            end else begin
               ld_lane++;
            end
         end
         SkipNl, WaitS: begin
            // newlines vanish only until the first other byte
            if (!(ld_phase == SkipNl && b == CharNl)) begin
               if (b == CharLowerS) begin
                  r[n] = reply(CharR);
                  n++;
                  ld_lane = '0;
                  ld_phase = GetCount;
               end else begin
                  r[n] = reply(CharE);
                  n++;
                  r[n] = reply(b);
                  n++;
                  ld_phase = WaitS;
               end
            end
         end
         GetCount: begin
            ld_remaining[ld_lane * 8 +: 8] = b;
            if (ld_lane == 2'd3) begin
               r[n] = reply(CharC);
               n++;
               ld_lane = '0;
               ld_ptr = ld_addr;
               if (ld_remaining == '0) begin
                  r[n].done_res = 1'b1;
                  r[n].jump_addr = ld_addr;
                  n++;
                  ld_phase = Finished;
               end else begin
                  ld_phase = LoadData;
               end
            end else begin
               ld_lane++;
            end
         end
         LoadData: begin
            r[n].wr_valid = 1'b1;
            r[n].wr_addr = ld_ptr;
            r[n].wr_data = b;
            n++;
            ld_ptr = ld_ptr + 1;   // wraps at 2^32
            ld_remaining = ld_remaining - 1;
            if (ld_remaining == '0) begin
               r[n].done_res = 1'b1;
               r[n].jump_addr = ld_addr;
               n++;
               ld_phase = Finished;
            end
         end
         default: begin
            // finished: later bytes are dropped silently
         end
      endcase
      if (n > 0)
         r[n - 1].last = 1'b1;
      if (keep)
         for (int i = 0; i < n; i++)
            expected_results.push_back(r[i]);
   endtask

   // offer one byte and hold it until the transfer; gaps come before valid rises
   task automatic send_byte(input byte_type b);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      bytes_sent++;
      // idle schedule: sender light / receiver heavy, then swapped, then none
      if (bytes_sent < 350) begin
         send_idle = 15;
         recv_idle = 56;
      end else if (bytes_sent < 700) begin
         send_idle = 56;
         recv_idle = 15;
      end else begin
         send_idle = 0;
         recv_idle = 0;
      end
   endtask

   task automatic send_predicted(input byte_type b);
      send_byte(b);
      advance_loader(b, 1'b1);
   endtask

   task automatic add_row(input byte_type rx, input int n_typed, input byte_type t0,
                          input byte_type t1);
      row_type r;
      r.rx = rx;
      r.n_typed = n_typed;
      r.t0 = t0;
      r.t1 = t1;
      dir_rows.push_back(r);
   endtask

   // result side: random ready, every result transfer checked against the oldest expectation
   always @(posedge clock) begin : rsp_side
      res_type got;
      res_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.tx_valid = rsp_tx_valid;
            got.tx_byte = rsp_tx_byte;
            got.wr_valid = rsp_wr_valid;
            got.wr_addr = rsp_wr_addr;
            got.wr_data = rsp_wr_data;
            got.done_res = rsp_done_res;
            got.jump_addr = rsp_jump_addr;
            got.last = rsp_last;
            if (expected_results.size() == 0) begin
               note_failure($sformatf("unexpected result %s", describe(got)));
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               if (!fields_match(got, want))
                  note_failure($sformatf("expected %s got %s", describe(want), describe(got)));
            end
            if (got.wr_valid === 1'b1) begin
               writes_seen++;
               if (got.wr_addr == '0)
                  wrap_seen = 1'b1;
            end
            if (got.done_res === 1'b1)
               done_seen = 1'b1;
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
   end

   // watchdog
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d results still expected", cycles,
         expected_results.size());
      $display("serial_image_loader_test failed");
      $finish;
   end

   initial begin : stimulus
      byte_type b;
      word_type image_len;

      // directed part: start-byte search, address at the top of memory so the
      // image wraps, newline skipping and the newline echo once skipping ends
      add_row(8'h00,       1,         CharE,       8'h00);
      add_row(8'hFF,       1,         CharE,       8'h00);
      add_row(CharUpperA,  1,         CharE,       8'h00);
      add_row(CharLowerS,  1,         CharE,       8'h00);
      add_row(CharNl,      1,         CharE,       8'h00);
      add_row(CharLowerA,  1,         CharUpperA,  8'h00);
      add_row(8'hF0,       Predicted, 8'h00,       8'h00);
      add_row(8'hFF,       Predicted, 8'h00,       8'h00);
      add_row(8'hFF,       Predicted, 8'h00,       8'h00);
      add_row(8'hFF,       1,         CharC,       8'h00);
      add_row(CharNl,      0,         8'h00,       8'h00);
      add_row(CharNl,      0,         8'h00,       8'h00);
      add_row(8'h00,       2,         CharE,       8'h00);
      add_row(CharNl,      2,         CharE,       CharNl);
      add_row(8'hFF,       2,         CharE,       8'hFF);
      add_row(CharLowerA,  2,         CharE,       CharLowerA);
      add_row(CharUpperA,  Predicted, 8'h00,       8'h00);
      add_row(8'h55,       Predicted, 8'h00,       8'h00);
      add_row(8'hAA,       Predicted, 8'h00,       8'h00);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         send_byte(dir_rows[i].rx);
         if (dir_rows[i].n_typed == Predicted) begin
            advance_loader(dir_rows[i].rx, 1'b1);
         end else begin
            // typed rows still step the predictor so its state follows the block
            advance_loader(dir_rows[i].rx, 1'b0);
            if (dir_rows[i].n_typed == 1) begin
               expected_results.push_back(reply(dir_rows[i].t0));
               expected_results[$].last = 1'b1;
            end else if (dir_rows[i].n_typed == 2) begin
               expected_results.push_back(reply(dir_rows[i].t0));
               expected_results.push_back(reply(dir_rows[i].t1));
               expected_results[$].last = 1'b1;
            end
         end
      end

      // random noise while waiting for the size command, newlines mixed in
      for (int i = 0; i < 160; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            b = CharNl;
         end else begin
            b = byte_type'($urandom_range(0, 255));
            if (b == CharLowerS)
               b = CharNl;
         end
         send_predicted(b);
      end

      // size command, little-endian length, then the image itself
      send_predicted(CharLowerS);
      image_len = word_type'($urandom_range(820, 880));
      for (int i = 0; i < 4; i++)
         send_predicted(image_len[i * 8 +: 8]);
      for (int i = 0; i < int'(image_len); i++)
         send_predicted(byte_type'($urandom_range(0, 255)));

      // bytes after completion must produce nothing
      for (int i = 0; i < 8; i++)
         send_predicted(byte_type'($urandom_range(0, 255)));
      req_valid <= 1'b0;

      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("sent %0d bytes through start, address, newline skip, size and %0d image bytes",
         bytes_sent, image_len);
      $display("checked %0d results: %0d writes, address wrap %0s, completion %0s",
         results_checked, writes_seen, wrap_seen ? "seen" : "missed",
         done_seen ? "seen" : "missed");
      if (failures == 0) begin
         $display("serial_image_loader_test passed");
      end else begin
         $display("%0d failures", failures);
         $display("serial_image_loader_test failed");
      end
      $finish;
   end

endmodule
